### rtl/ptd_pkg.sv
// Shared types, constants and controller/datapath command structs for the prefix trie.
`default_nettype none

package ptd_pkg;

  // Default size of the node pool, root included.
  localparam int unsigned NodeCountDefault = 512;
  // Number of child links per node, one per lower-case letter.
  localparam int unsigned AlphabetSize = 26;
  // Width of the node count reported with each result word.
  localparam int unsigned CountOutWidth = 10;

  // Range of accepted character bytes.
  localparam logic [7:0] CharFirst = 8'd97;
  localparam logic [7:0] CharLast  = 8'd122;

  // Operation codes sampled on the first word of a dictionary word.
  typedef logic [1:0] op_t;
  localparam op_t OpInsert   = 2'd0;
  localparam op_t OpContains = 2'd1;
  localparam op_t OpPrefix   = 2'd2;

  // Letter index within a node row.
  typedef logic [4:0] letter_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ready;         // input channel may take a word
    logic take;          // input word accepted this cycle
    logic rd_row;        // read the row of the walk's node
    logic mark_rd_cur;   // read the word mark of the walk's node
    logic mark_rd_link;  // read the word mark of the selected child
    logic follow;        // move the walk to the selected child
    logic alloc;         // link a new node and move the walk to it
    logic abort;         // mark the word as rejected
    logic clear;         // wipe the row and mark of the walk's node
    logic finish;        // load the result register and end the word
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;   // input word offered
    logic row_rd;     // offered word carries a letter that must be walked
    logic in_last;    // offered word ends the dictionary word
    logic item_last;  // word in flight ends the dictionary word
    logic link_hit;   // child link of the read row is present
    logic may_alloc;  // insert in progress and a free node is left
    logic out_free;   // result register can be loaded
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/ptd_in_if.sv
// Input channel interface: one character word per handshake.
`default_nettype none

interface ptd_in_if import ptd_pkg::*; ();

  logic       valid;
  logic       ready;
  op_t        op;
  logic [7:0] ch;
  logic       empty_word;
  logic       last;

  modport source (output valid, op, ch, empty_word, last, input ready);
  modport sink   (input valid, op, ch, empty_word, last, output ready);

endinterface

`default_nettype wire

### rtl/ptd_out_if.sv
// Result channel interface: one answer word per dictionary word.
`default_nettype none

interface ptd_out_if import ptd_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic                     found;
  logic                     insert_failed;
  logic [CountOutWidth-1:0] nodes_in_use;

  modport source (output valid, found, insert_failed, nodes_in_use, input ready);
  modport sink   (input valid, found, insert_failed, nodes_in_use, output ready);

endinterface

`default_nettype wire

### rtl/ptd_ctrl.sv
// Controller state machine that sequences lookups, allocations and results.
`default_nettype none

module ptd_ctrl import ptd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StStep   = 4'b0010,
    StClear  = 4'b0100,
    StFinish = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        cmd_o.ready = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.take = 1'b1;
          if (stat_i.row_rd) begin
            cmd_o.rd_row = 1'b1;
            state_d      = StStep;
          end else if (stat_i.in_last) begin
            cmd_o.mark_rd_cur = 1'b1;
            state_d           = StFinish;
          end
        end
      end
      StStep: begin
        if (stat_i.link_hit) begin
          cmd_o.follow = 1'b1;
          if (stat_i.item_last) begin
            cmd_o.mark_rd_link = 1'b1;
            state_d            = StFinish;
          end else begin
            state_d = StIdle;
          end
        end else if (stat_i.may_alloc) begin
          cmd_o.alloc = 1'b1;
          state_d     = StClear;
        end else begin
          cmd_o.abort = 1'b1;
          state_d     = stat_i.item_last ? StFinish : StIdle;
        end
      end
      StClear: begin
        cmd_o.clear = 1'b1;
        state_d     = stat_i.item_last ? StFinish : StIdle;
      end
      StFinish: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/ptd_datapath.sv
// Datapath: node row and word mark memories, walk registers and result register.
`default_nettype none

module ptd_datapath import ptd_pkg::*; #(
  parameter int unsigned NODE_COUNT = NodeCountDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ptd_in_if.sink       in_i,
  ptd_out_if.source    out_o,
  input  dp_cmd_t      cmd_i,
  output dp_stat_t     stat_o
);

  localparam int unsigned NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned CW = $clog2(NODE_COUNT + 1);

  typedef logic [NW-1:0] node_t;
  typedef logic [AlphabetSize-1:0][NW-1:0] row_t;

  // Walk state.
  node_t         cur_q;
  logic [CW-1:0] count_q;
  op_t           word_op_q;
  logic          aborted_q;
  logic          mid_word_q;
  logic          last_q;
  letter_t       letter_q;
  logic          links_root_ok_q;
  logic          mark_root_ok_q;

  // Memories and their read registers.
  row_t          row_mem [NODE_COUNT];
  logic          mark_mem [NODE_COUNT];
  row_t          row_rd_q;
  logic          row_zero_q;
  logic          mark_rd_q;
  logic          mark_zero_q;

  // Result register.
  logic                     out_valid_q;
  logic                     out_found_q;
  logic                     out_failed_q;
  logic [CountOutWidth-1:0] out_nodes_q;

  // Decode of the offered input word against the word in progress.
  op_t        op_eff;
  logic       abort_eff;
  logic       op_known;
  logic       char_act;
  logic       letter_ok;
  logic [7:0] letter_diff;
  node_t      base_node;

  always_comb begin
    op_eff      = mid_word_q ? word_op_q : in_i.op;
    abort_eff   = mid_word_q & aborted_q;
    op_known    = (op_eff == OpInsert) || (op_eff == OpContains) || (op_eff == OpPrefix);
    char_act    = !in_i.empty_word && !abort_eff && op_known;
    letter_ok   = (in_i.ch >= CharFirst) && (in_i.ch <= CharLast);
    letter_diff = in_i.ch - CharFirst;
    base_node   = mid_word_q ? cur_q : '0;
  end

  // Child selection from the row just read; an unwritten root row reads empty.
  row_t  row_eff;
  node_t link;
  node_t new_node;
  logic  mark_eff;

  always_comb begin
    row_eff  = row_zero_q ? '0 : row_rd_q;
    link     = row_eff[letter_q];
    new_node = count_q[NW-1:0];
    mark_eff = mark_rd_q & !mark_zero_q;
  end

  // Row write data: link a new child, or wipe a freshly allocated row.
  logic  row_we;
  row_t  row_wdata;

  always_comb begin
    row_we    = cmd_i.alloc | cmd_i.clear;
    row_wdata = row_eff;
    if (cmd_i.alloc) begin
      row_wdata[letter_q] = new_node;
    end
    if (cmd_i.clear) begin
      row_wdata = '0;
    end
  end

  // Word mark writes: cleared on allocation, set when an insert completes.
  logic  insert_ok;
  logic  mark_we;
  logic  mark_wdata;
  node_t mark_rd_addr;

  always_comb begin
    insert_ok    = (word_op_q == OpInsert) && !aborted_q;
    mark_we      = cmd_i.clear | (cmd_i.finish & insert_ok);
    mark_wdata   = !cmd_i.clear;
    mark_rd_addr = cmd_i.mark_rd_link ? link : base_node;
  end

  // Node row memory.
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[cur_q] <= row_wdata;
    end
    if (cmd_i.rd_row) begin
      row_rd_q <= row_mem[base_node];
    end
  end

  // Word mark memory.
  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[cur_q] <= mark_wdata;
    end
    if (cmd_i.mark_rd_cur | cmd_i.mark_rd_link) begin
      mark_rd_q <= mark_mem[mark_rd_addr];
    end
  end

  // Result fields computed at the end of a word.
  logic                        res_found;
  logic [CW+CountOutWidth-1:0] count_ext;

  always_comb begin
    case (word_op_q)
      OpContains: res_found = !aborted_q && mark_eff;
      OpPrefix:   res_found = !aborted_q;
      default:    res_found = 1'b0;
    endcase
    count_ext = (CW + CountOutWidth)'(count_q);
  end

  // Walk and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q           <= '0;
      count_q         <= CW'(1);
      word_op_q       <= OpInsert;
      aborted_q       <= 1'b0;
      mid_word_q      <= 1'b0;
      last_q          <= 1'b0;
      links_root_ok_q <= 1'b0;
      mark_root_ok_q  <= 1'b0;
      row_zero_q      <= 1'b0;
      mark_zero_q     <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        mid_word_q <= 1'b1;
        word_op_q  <= op_eff;
        cur_q      <= base_node;
        aborted_q  <= abort_eff | (char_act & !letter_ok);
        last_q     <= in_i.last;
      end
      if (cmd_i.rd_row) begin
        row_zero_q <= (base_node == '0) && !links_root_ok_q;
      end
      if (cmd_i.mark_rd_cur | cmd_i.mark_rd_link) begin
        mark_zero_q <= (mark_rd_addr == '0) && !mark_root_ok_q;
      end
      if (cmd_i.follow) begin
        cur_q <= link;
      end
      if (cmd_i.alloc) begin
        cur_q   <= new_node;
        count_q <= count_q + CW'(1);
        if (cur_q == '0) begin
          links_root_ok_q <= 1'b1;
        end
      end
      if (cmd_i.abort) begin
        aborted_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        mid_word_q <= 1'b0;
        if (insert_ok && (cur_q == '0)) begin
          mark_root_ok_q <= 1'b1;
        end
      end
      // Result valid: set on finish, dropped once the word is taken.
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      letter_q <= letter_diff[4:0];
    end
    if (cmd_i.finish) begin
      out_found_q  <= res_found;
      out_failed_q <= (word_op_q == OpInsert) && aborted_q;
      out_nodes_q  <= count_ext[CountOutWidth-1:0];
    end
  end

  // Channel and status outputs.
  assign in_i.ready          = cmd_i.ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.found         = out_found_q;
  assign out_o.insert_failed = out_failed_q;
  assign out_o.nodes_in_use  = out_nodes_q;

  always_comb begin
    stat_o.in_valid  = in_i.valid;
    stat_o.row_rd    = char_act && letter_ok;
    stat_o.in_last   = in_i.last;
    stat_o.item_last = last_q;
    stat_o.link_hit  = (link != '0);
    stat_o.may_alloc = (word_op_q == OpInsert) && (count_q < CW'(NODE_COUNT));
    stat_o.out_free  = !out_valid_q || out_o.ready;
  end

endmodule

`default_nettype wire

### rtl/prefix_trie_dictionary.sv
// Top level of the prefix trie dictionary: controller and datapath.
//
// Usage: words arrive on in_i one character per word, last set on the final
// one; op is taken from the first word of each dictionary word (insert,
// contains, has prefix). One result word leaves on out_o per dictionary
// word, after its final character.
// Steps per input word: a word with no letter to walk is only accepted; a letter
// is accepted with a row read, then the link decision is made, and when an insert
// allocates a node the new row is wiped. The final word then loads the result
// register once it is free, visible the cycle after.
// Throughput is set by the single node row memory, which is read for each letter
// and written when an insert allocates, so one input word is in flight at a time.
// Reset empties the trie at once (root row and mark read empty until first
// written); no clearing pass is needed. When out_o stalls, the result waits
// in its register and the next dictionary word is still taken up to its
// final character, which waits until the register frees.
`default_nettype none

module prefix_trie_dictionary import ptd_pkg::*; #(
  parameter int unsigned NODE_COUNT = NodeCountDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptd_in_if.sink    in_i,
  ptd_out_if.source out_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ptd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  ptd_datapath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

`default_nettype wire

### rtl/ptd_checker.sv
// Port-level checker for the prefix trie dictionary and its bind statement.
`default_nettype none

module ptd_checker import ptd_pkg::*; #(
  parameter int unsigned NODE_COUNT = NodeCountDefault
) (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_i,
  input wire logic                     in_last_i,
  input wire logic                     out_valid_i,
  input wire logic                     out_ready_i,
  input wire logic                     out_found_i,
  input wire logic                     out_failed_i,
  input wire logic [CountOutWidth-1:0] out_nodes_i
);

  // A stalled result word holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_found_i)
      && $stable(out_failed_i) && $stable(out_nodes_i))
    else $error("result word changed while stalled");

  // A word is never both an answer and a rejected insert.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_found_i && out_failed_i))
    else $error("found and insert_failed both set");

  // Input ready drops after the final character of a word is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input ready right after a final character");

  // The root is always counted while the count fits the result field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (NODE_COUNT >= 1024) || (out_nodes_i != '0))
    else $error("node count reported as zero");

endmodule

bind prefix_trie_dictionary ptd_checker #(
  .NODE_COUNT (NODE_COUNT)
) u_ptd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_last_i    (in_i.last),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_found_i  (out_o.found),
  .out_failed_i (out_o.insert_failed),
  .out_nodes_i  (out_o.nodes_in_use)
);

`default_nettype wire

### tb/prefix_trie_checker.sv
// Checker for the prefix trie dictionary: tracks the trie, predicts each answer word and compares.
`default_nettype none

module prefix_trie_checker import ptd_pkg::*; #(
  parameter int unsigned NODE_COUNT = NodeCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptd_in_if           in_mon,
  ptd_out_if          out_mon,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned found_o,
  output int unsigned rejected_o,
  output int unsigned peak_o
);

  typedef struct packed {
    logic                     found;
    logic                     insert_failed;
    logic [CountOutWidth-1:0] nodes_in_use;
  } answer_t;

  // Shadow copy of the trie. A link value of zero means no child, since the
  // root is never anyone's child.
  int unsigned trie_link [NODE_COUNT][AlphabetSize];
  bit          word_mark [NODE_COUNT];
  int unsigned pool_used;
  int unsigned walk_node;
  bit          word_rejected;
  bit          in_word;
  op_t         word_cmd;

  // Answers still owed by the block, oldest first.
  answer_t answer_q[$];

  // Advances the walk by one input word. Returns 1 when the word ends a
  // dictionary word, with the answer that the block must give for it.
  function automatic bit walk_char(input op_t op, input logic [7:0] ch,
                                   input logic no_char, input logic ends,
                                   output answer_t ans);
    int unsigned letter;
    int unsigned child;
    ans = '0;
    if (!in_word) begin
      word_cmd      = op;
      walk_node     = 0;
      word_rejected = 1'b0;
      in_word       = 1'b1;
    end

    // Walk one letter; inserts grow the trie, queries stop at a gap.
    if (!no_char && !word_rejected && word_cmd <= OpPrefix) begin
      if (ch < CharFirst || ch > CharLast) begin
        word_rejected = 1'b1;
      end else begin
        letter = ch - CharFirst;
        child  = trie_link[walk_node][letter];
        if (child != 0) begin
          walk_node = child;
        end else if (word_cmd != OpInsert || pool_used >= NODE_COUNT) begin
          word_rejected = 1'b1;
        end else begin
          for (int k = 0; k < AlphabetSize; k++) trie_link[pool_used][k] = 0;
          word_mark[pool_used]         = 1'b0;
          trie_link[walk_node][letter] = pool_used;
          walk_node                    = pool_used;
          pool_used++;
        end
      end
    end

    if (!ends) return 1'b0;

    // The final character settles the answer.
    in_word = 1'b0;
    case (word_cmd)
      OpInsert: begin
        if (word_rejected) ans.insert_failed = 1'b1;
        else word_mark[walk_node] = 1'b1;
      end
      OpContains: ans.found = !word_rejected && word_mark[walk_node];
      OpPrefix:   ans.found = !word_rejected;
      default: ;
    endcase
    ans.nodes_in_use = CountOutWidth'(pool_used);
    return 1'b1;
  endfunction

  // Compare answers as they leave, then account for the word taken in.
  always @(posedge clk_i or negedge rst_ni) begin : track
    answer_t want;
    answer_t fresh;
    if (!rst_ni) begin
      for (int n = 0; n < NODE_COUNT; n++) begin
        for (int k = 0; k < AlphabetSize; k++) trie_link[n][k] = 0;
        word_mark[n] = 1'b0;
      end
      pool_used     = 1;
      walk_node     = 0;
      word_rejected = 1'b0;
      in_word       = 1'b0;
      word_cmd      = OpInsert;
      answer_q.delete();
      errors_o   = 0;
      pending_o  = 0;
      checked_o  = 0;
      found_o    = 0;
      rejected_o = 0;
      peak_o     = 1;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (answer_q.size() == 0) begin
          errors_o++;
          $display("%0t: answer word with none expected: found=%0b failed=%0b nodes=%0d",
                   $time, out_mon.found, out_mon.insert_failed, out_mon.nodes_in_use);
        end else begin
          want = answer_q.pop_front();
          checked_o++;
          if (want.found) found_o++;
          if (want.insert_failed) rejected_o++;
          if (out_mon.found !== want.found) begin
            errors_o++;
            $display("%0t: found mismatch, expected %0b, got %0b",
                     $time, want.found, out_mon.found);
          end
          if (out_mon.insert_failed !== want.insert_failed) begin
            errors_o++;
            $display("%0t: insert_failed mismatch, expected %0b, got %0b",
                     $time, want.insert_failed, out_mon.insert_failed);
          end
          if (out_mon.nodes_in_use !== want.nodes_in_use) begin
            errors_o++;
            $display("%0t: nodes_in_use mismatch, expected %0d, got %0d",
                     $time, want.nodes_in_use, out_mon.nodes_in_use);
          end
        end
      end
      if (in_mon.valid && in_mon.ready &&
          walk_char(in_mon.op, in_mon.ch, in_mon.empty_word, in_mon.last, fresh)) begin
        answer_q.push_back(fresh);
      end
      pending_o = answer_q.size();
      if (pool_used > peak_o) peak_o = pool_used;
    end
  end

endmodule

`default_nettype wire

### tb/tb_prefix_trie_dictionary.sv
// Testbench top for the prefix trie dictionary: stimulus, handshake idling and verdict.
`default_nettype none

module tb_prefix_trie_dictionary;
  import ptd_pkg::*;

  localparam int unsigned NodeCount  = NodeCountDefault;
  localparam op_t         OpUnused   = 2'd3;
  localparam int          TotalItems = 1700;
  localparam int          IdleLimit  = 1000;
  localparam int          TailCycles = 16;
  localparam int          LexiconMax = 48;

  logic clk_i = 1'b0;
  logic rst_ni;

  ptd_in_if  in_if ();
  ptd_out_if out_if ();

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned hits;
  int unsigned rejects;
  int unsigned peak;

  // Sender pacing and bookkeeping.
  int    burst_left = 0;
  bit    calm_sender = 1'b0;
  int    items_sent = 0;
  int    words_by_op [4] = '{0, 0, 0, 0};
  string lexicon[$];

  // Receiver pacing.
  int rx_mode = 0;
  int rx_run  = 0;
  int rx_hold = 0;
  bit rx_low  = 1'b0;

  int idle_cycles = 0;

  prefix_trie_dictionary #(.NODE_COUNT(NodeCount)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  prefix_trie_checker #(.NODE_COUNT(NodeCount)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked),
    .found_o    (hits),
    .rejected_o (rejects),
    .peak_o     (peak)
  );

  // Clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stalls: switches between always ready, random stalls and long
  // stall runs.
  always @(negedge clk_i) begin
    if (rx_run == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_run  = $urandom_range(100, 400);
    end
    rx_run--;
    case (rx_mode)
      0: out_if.ready = 1'b1;
      1: out_if.ready = ($urandom_range(0, 2) != 0);
      default: begin
        if (rx_hold == 0) begin
          rx_low  = !rx_low;
          rx_hold = rx_low ? $urandom_range(1, 25) : $urandom_range(1, 8);
        end
        rx_hold--;
        out_if.ready = !rx_low;
      end
    endcase
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offers one word and holds it until accepted. Gaps fall between bursts.
  task automatic drive_item(input op_t op, input logic [7:0] ch, input logic no_char,
                            input logic ends);
    int gap;
    if (burst_left == 0) begin
      gap = calm_sender ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_if.valid      = 1'b1;
    in_if.op         = op;
    in_if.ch         = ch;
    in_if.empty_word = no_char;
    in_if.last       = ends;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // Sends a dictionary word, one character per word, with optional empty
  // words in front of characters. Only the first word carries a real op.
  task automatic send_word(input op_t op, input string w, input int pad_pct);
    bit first;
    first = 1'b1;
    words_by_op[op]++;
    if (w.len() == 0) begin
      drive_item(op, 8'($urandom_range(1, 255)), 1'b1, 1'b1);
    end else begin
      for (int i = 0; i < w.len(); i++) begin
        if ($urandom_range(0, 99) < pad_pct) begin
          drive_item(first ? op : op_t'($urandom_range(0, 3)),
                     8'($urandom_range(1, 255)), 1'b1, 1'b0);
          first = 1'b0;
        end
        drive_item(first ? op : op_t'($urandom_range(0, 3)), w[i], 1'b0,
                   i == w.len() - 1);
        first = 1'b0;
      end
    end
  endtask

  function automatic string rand_letters(input int n);
    string s;
    s = "";
    repeat (n) s = $sformatf("%s%c", s, $urandom_range(CharFirst, CharLast));
    return s;
  endfunction

  function automatic logic [7:0] bad_byte();
    if ($urandom_range(0, 1) != 0) return 8'($urandom_range(1, CharFirst - 1));
    return 8'($urandom_range(CharLast + 1, 255));
  endfunction

  // A word inserted earlier, so that queries often hit.
  function automatic string known_word();
    if (lexicon.size() == 0) return rand_letters($urandom_range(1, 5));
    return lexicon[$urandom_range(0, lexicon.size() - 1)];
  endfunction

  function automatic string prefix_of(input string s);
    return s.substr(0, $urandom_range(0, s.len() - 1));
  endfunction

  function automatic void remember(input string s);
    lexicon.push_back(s);
    if (lexicon.size() > LexiconMax) void'(lexicon.pop_front());
  endfunction

  initial begin : stimulus
    int    r;
    int    sel;
    string w;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.op         = OpInsert;
    in_if.ch         = CharFirst;
    in_if.empty_word = 1'b0;
    in_if.last       = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty words against the bare root, then marking the root.
    send_word(OpContains, "", 0);
    send_word(OpPrefix, "", 0);
    send_word(OpInsert, "", 0);
    send_word(OpContains, "", 0);
    // Both ends of the alphabet, whole words against prefixes.
    send_word(OpInsert, "az", 0);
    send_word(OpContains, "az", 0);
    send_word(OpContains, "a", 0);
    send_word(OpPrefix, "a", 0);
    // A bad byte mid-insert keeps the node already made but sets no mark.
    send_word(OpInsert, $sformatf("b%cc", 8'd255), 0);
    send_word(OpPrefix, "b", 0);
    send_word(OpContains, "b", 0);
    // Bytes outside the letter range, two of them just outside.
    send_word(OpContains, $sformatf("%c", 8'd1), 0);
    send_word(OpInsert, $sformatf("%c", CharFirst - 8'd1), 0);
    send_word(OpPrefix, $sformatf("%c", CharLast + 8'd1), 0);
    // Empty words inside a word add nothing.
    send_word(OpInsert, "cd", 100);
    send_word(OpContains, "cd", 0);
    // Unused op and a query down a missing link.
    send_word(OpUnused, "a", 0);
    send_word(OpContains, "q", 0);

    // Random words: mostly inserts of fresh words so the pool fills, queries
    // aimed at known words, and some malformed traffic.
    while (items_sent < TotalItems) begin
      if ($urandom_range(0, 29) == 0) calm_sender = ($urandom_range(0, 3) == 0);
      r   = $urandom_range(0, 99);
      sel = $urandom_range(0, 4);
      if (r < 45) begin
        w = rand_letters($urandom_range(1, 12));
        if ($urandom_range(0, 9) == 0) w[$urandom_range(0, w.len() - 1)] = bad_byte();
        remember(w);
        send_word(OpInsert, w, 5);
      end else if (r < 55) begin
        w = {known_word(), rand_letters($urandom_range(0, 3))};
        remember(w);
        send_word(OpInsert, w, 5);
      end else if (r < 70) begin
        if (sel < 3) w = known_word();
        else if (sel == 3) w = prefix_of(known_word());
        else w = rand_letters($urandom_range(1, 6));
        send_word(OpContains, w, 5);
      end else if (r < 85) begin
        if (sel < 3) w = prefix_of(known_word());
        else if (sel == 3) w = {known_word(), rand_letters(1)};
        else w = rand_letters($urandom_range(1, 6));
        send_word(OpPrefix, w, 5);
      end else if (r < 90) begin
        send_word(op_t'($urandom_range(0, 3)), "", 0);
      end else if (r < 95) begin
        send_word(OpUnused, rand_letters($urandom_range(1, 6)), 5);
      end else begin
        w = known_word();
        w[$urandom_range(0, w.len() - 1)] = bad_byte();
        send_word(($urandom_range(0, 1) != 0) ? OpContains : OpPrefix, w, 5);
      end
    end
    in_if.valid = 1'b0;

    // Drain the remaining answers, then watch for stray ones.
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d words in %0d items: %0d inserts, %0d contains, %0d prefix, %0d unused op.",
             words_by_op[0] + words_by_op[1] + words_by_op[2] + words_by_op[3], items_sent,
             words_by_op[0], words_by_op[1], words_by_op[2], words_by_op[3]);
    $display("Checked %0d answers (%0d found, %0d rejected inserts); pool peaked at %0d of %0d.",
             checked, hits, rejects, peak, NodeCount);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
